FILE: rtl/jsu_pkg.sv
// Package for the JSON string unescaper: result kinds, error codes,
// character constants and the request record passed from front to back.
// No dependencies.
package jsu_pkg;

  localparam int JSU_QDEPTH = 4;
  localparam int JSU_QPW    = $clog2(JSU_QDEPTH);
  localparam int JSU_MAXB   = 4;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_CTRL  = 8'h20;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_NOT_QUOTE = 4'd1,
    ERR_CONTROL   = 4'd2,
    ERR_OPEN_ESC  = 4'd3,
    ERR_BAD_ESC   = 4'd4,
    ERR_SHORT_HEX = 4'd5,
    ERR_BAD_HEX   = 4'd6,
    ERR_NO_LOW    = 4'd7,
    ERR_BAD_LOW   = 4'd8,
    ERR_UNTERM    = 4'd9
  } err_t;

  typedef struct packed {
    logic [2:0]            nd;
    logic [JSU_MAXB-1:0][7:0] data;
    logic                  has_tail;
    kind_t                 tail_kind;
    err_t                  err;
  } jsu_req_t;

endpackage

FILE: rtl/jsu_in_if.sv
// Input channel of the JSON string unescaper: one source byte per request.
// Depends on nothing.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

FILE: rtl/jsu_out_if.sv
// Output channel of the JSON string unescaper: one result item per request.
// Depends on nothing.
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic [3:0] error_code;
  logic       last_of_run;

  modport source (output valid, output out_byte, output out_kind, output error_code,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input out_kind, input error_code,
                  input last_of_run, output ready);
endinterface

FILE: rtl/jsu_front.sv
// Front end: accepts source bytes, runs the string decode state machine and
// builds one request of up to four UTF-8 bytes plus an end or error mark.
// Depends on jsu_pkg and jsu_in_if.
module jsu_front
  import jsu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  jsu_in_if.sink      in_chan,
  input  logic        q_full,
  output logic        q_push,
  output jsu_req_t    q_wdata
);

  typedef enum logic [6:0] {
    M_IDLE = 7'b0000001,
    M_STR  = 7'b0000010,
    M_ESC  = 7'b0000100,
    M_HEX1 = 7'b0001000,
    M_BSL  = 7'b0010000,
    M_LOWU = 7'b0100000,
    M_HEX2 = 7'b1000000
  } mode_t;

  mode_t       mode, mode_next;
  logic [15:0] accum, accum_next;
  logic [9:0]  high_half, high_next;
  logic [1:0]  count, count_next;
  logic        bad, bad_next;

  logic [7:0]  b;
  logic        last;
  logic        accept;
  logic [3:0]  dval;
  logic        dbad;
  logic [15:0] acc_shift;
  logic        bad_total;
  logic        fire_err;
  err_t        ecode;
  logic [7:0]  esc_val;
  logic        esc_simple;
  jsu_req_t    req;

  function automatic jsu_req_t encode(input logic [20:0] cp);
    jsu_req_t r;
    r = '0;
    if (cp <= 21'h7F) begin
      r.nd = 3'd1;
      r.data[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      r.nd = 3'd2;
      r.data[0] = {3'b110, cp[10:6]};
      r.data[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      r.nd = 3'd3;
      r.data[0] = {4'b1110, cp[15:12]};
      r.data[1] = {2'b10, cp[11:6]};
      r.data[2] = {2'b10, cp[5:0]};
    end else begin
      r.nd = 3'd4;
      r.data[0] = {5'b11110, cp[20:18]};
      r.data[1] = {2'b10, cp[17:12]};
      r.data[2] = {2'b10, cp[11:6]};
      r.data[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

  assign b      = in_chan.in_byte;
  assign last   = in_chan.in_last;
  assign in_chan.ready = !q_full;
  assign accept = in_chan.valid && !q_full;

  always_comb begin
    dval = 4'd0;
    dbad = 1'b0;
    case (b) inside
      [8'h30:8'h39]: dval = b[3:0];
      [8'h61:8'h66], [8'h41:8'h46]: dval = 4'(b[3:0] + 4'd9);
      default: dbad = 1'b1;
    endcase
  end

  always_comb begin
    esc_simple = 1'b1;
    esc_val    = 8'h00;
    case (b)
      CH_QUOTE: esc_val = CH_QUOTE;
      CH_BSL:   esc_val = CH_BSL;
      CH_SLASH: esc_val = CH_SLASH;
      8'h62:    esc_val = 8'h08;
      8'h66:    esc_val = 8'h0C;
      8'h6E:    esc_val = 8'h0A;
      8'h72:    esc_val = 8'h0D;
      8'h74:    esc_val = 8'h09;
      default:  esc_simple = 1'b0;
    endcase
  end

  assign acc_shift = {accum[11:0], dval};
  assign bad_total = bad || dbad;

  always_comb begin
    mode_next  = mode;
    accum_next = accum;
    high_next  = high_half;
    count_next = count;
    bad_next   = bad;
    fire_err   = 1'b0;
    ecode      = ERR_NONE;
    req        = '0;
    case (mode)
      M_STR: begin
        if (b == CH_QUOTE) begin
          mode_next     = M_IDLE;
          req.has_tail  = 1'b1;
          req.tail_kind = KIND_END;
        end else if (b < CH_CTRL) begin
          fire_err = 1'b1;
          ecode    = ERR_CONTROL;
        end else if (b == CH_BSL) begin
          if (last) begin
            fire_err = 1'b1;
            ecode    = ERR_OPEN_ESC;
          end else begin
            mode_next = M_ESC;
          end
        end else begin
          req.nd      = 3'd1;
          req.data[0] = b;
        end
      end
      M_ESC: begin
        if (esc_simple) begin
          mode_next   = M_STR;
          req.nd      = 3'd1;
          req.data[0] = esc_val;
        end else if (b == CH_U) begin
          accum_next = '0;
          count_next = '0;
          bad_next   = 1'b0;
          if (last) begin
            fire_err = 1'b1;
            ecode    = ERR_SHORT_HEX;
          end else begin
            mode_next = M_HEX1;
          end
        end else begin
          fire_err = 1'b1;
          ecode    = ERR_BAD_ESC;
        end
      end
      M_HEX1, M_HEX2: begin
        accum_next = acc_shift;
        bad_next   = bad_total;
        if (count != 2'd3) begin
          count_next = 2'(count + 2'd1);
          if (last) begin
            fire_err = 1'b1;
            ecode    = ERR_SHORT_HEX;
          end
        end else begin
          count_next = '0;
          if (bad_total) begin
            fire_err = 1'b1;
            ecode    = ERR_BAD_HEX;
          end else if (mode == M_HEX1) begin
            if (acc_shift[15:10] == 6'b110110) begin
              high_next = acc_shift[9:0];
              if (last) begin
                fire_err = 1'b1;
                ecode    = ERR_NO_LOW;
              end else begin
                mode_next = M_BSL;
              end
            end else begin
              mode_next = M_STR;
              req       = encode({5'd0, acc_shift});
            end
          end else begin
            if (acc_shift[15:10] != 6'b110111) begin
              fire_err = 1'b1;
              ecode    = ERR_BAD_LOW;
            end else begin
              mode_next = M_STR;
              req       = encode({11'(high_half) + 11'd64, acc_shift[9:0]});
            end
          end
        end
      end
      M_BSL: begin
        if (b != CH_BSL || last) begin
          fire_err = 1'b1;
          ecode    = ERR_NO_LOW;
        end else begin
          mode_next = M_LOWU;
        end
      end
      M_LOWU: begin
        if (b != CH_U) begin
          fire_err = 1'b1;
          ecode    = ERR_NO_LOW;
        end else begin
          accum_next = '0;
          count_next = '0;
          bad_next   = 1'b0;
          if (last) begin
            fire_err = 1'b1;
            ecode    = ERR_SHORT_HEX;
          end else begin
            mode_next = M_HEX2;
          end
        end
      end
      default: begin
        if (b != CH_QUOTE) begin
          fire_err = 1'b1;
          ecode    = ERR_NOT_QUOTE;
        end else if (last) begin
          fire_err = 1'b1;
          ecode    = ERR_UNTERM;
        end else begin
          mode_next = M_STR;
        end
      end
    endcase
    if (req.nd != 3'd0 && last) begin
      fire_err = 1'b1;
      ecode    = ERR_UNTERM;
    end
    if (fire_err) begin
      mode_next     = M_IDLE;
      req.has_tail  = 1'b1;
      req.tail_kind = KIND_ERR;
      req.err       = ecode;
    end
  end

  assign q_push  = accept && (req.has_tail || req.nd != 3'd0);
  assign q_wdata = req;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      accum     <= '0;
      high_half <= '0;
      count     <= '0;
      bad       <= 1'b0;
    end else if (accept) begin
      mode      <= mode_next;
      accum     <= accum_next;
      high_half <= high_next;
      count     <= count_next;
      bad       <= bad_next;
    end
  end

endmodule

FILE: rtl/jsu_queue.sv
// Request queue between front and back of the unescaper, JSU_QDEPTH deep.
// Depends on jsu_pkg.
module jsu_queue
  import jsu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  jsu_req_t wdata,
  input  logic     pop,
  output jsu_req_t rdata,
  output logic     full,
  output logic     empty
);

  jsu_req_t           mem [JSU_QDEPTH];
  logic [JSU_QPW-1:0] wr_ptr;
  logic [JSU_QPW-1:0] rd_ptr;
  logic [JSU_QPW:0]   count;

  assign full  = (count == (JSU_QPW + 1)'(JSU_QDEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == JSU_QPW'(JSU_QDEPTH - 1)) ? '0 : JSU_QPW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == JSU_QPW'(JSU_QDEPTH - 1)) ? '0 : JSU_QPW'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= (JSU_QPW + 1)'(count + 1'b1);
      end else if (pop && !push) begin
        count <= (JSU_QPW + 1)'(count - 1'b1);
      end
    end
  end

endmodule

FILE: rtl/jsu_back.sv
// Back end: hands out the result items of queue requests one per cycle while
// ready, data bytes first, then the end or error mark. Depends on jsu_pkg.
module jsu_back
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  jsu_req_t   q_rdata,
  output logic       q_pop,
  jsu_out_if.source  out_chan
);

  jsu_req_t   cur;
  logic       cur_valid;
  logic [2:0] idx;
  logic [2:0] total;
  logic       is_data;
  logic       is_last;
  logic       take;

  assign total   = 3'(cur.nd + {2'd0, cur.has_tail});
  assign is_data = idx < cur.nd;
  assign is_last = (idx == 3'(total - 3'd1));
  assign take    = cur_valid && out_chan.ready;
  assign q_pop   = !q_empty && (!cur_valid || (take && is_last));

  assign out_chan.valid       = cur_valid;
  assign out_chan.out_byte    = is_data ? cur.data[idx[1:0]] : 8'h00;
  assign out_chan.out_kind    = is_data ? KIND_DATA : cur.tail_kind;
  assign out_chan.error_code  = is_data ? ERR_NONE : cur.err;
  assign out_chan.last_of_run = is_last;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (!cur_valid || (take && is_last)) begin
      cur_valid <= !q_empty;
      idx       <= '0;
    end else if (take) begin
      idx <= 3'(idx + 3'd1);
    end
  end

endmodule

FILE: rtl/json_string_unescape_top.sv
// Top level of the JSON string unescaper: front end, request queue, back end.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if, jsu_front, jsu_queue, jsu_back.
//
// Takes one source byte per cycle, starting at the opening quote, and gives
// the decoded string as UTF-8 data items, followed by an end item at the
// closing quote or an error item with its code. Each byte is decoded in the
// cycle it is accepted and yields 0 to 5 result items; the output port hands
// out one item per cycle while the sink is ready. When nothing is ahead of
// it, the request of a byte passes the queue memory and the back end's
// current-request register before its first item can be taken. A four-entry
// request queue sits between decoder and output, so input is taken at one
// byte per cycle whenever the queue has room, and a stalled output only
// stops input once four requests wait in the queue behind the one being
// handed out. The item with last_of_run set closes the results of one byte.
// No clearing pass: the block is ready the cycle after reset.
module json_string_unescape_top
  import jsu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  jsu_in_if.sink    in_chan,
  jsu_out_if.source out_chan
);

  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;
  jsu_req_t q_wdata;
  jsu_req_t q_rdata;

  jsu_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  jsu_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  jsu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_rdata  (q_rdata),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("request pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("request popped from empty queue");

  a_err_closes: assert property (@(posedge clk) disable iff (rst)
    (out_chan.valid && out_chan.out_kind == KIND_ERR) |-> out_chan.last_of_run)
    else $error("error item not last of its run");

  a_data_no_code: assert property (@(posedge clk) disable iff (rst)
    (out_chan.valid && out_chan.out_kind == KIND_DATA) |-> out_chan.error_code == ERR_NONE)
    else $error("data item carries an error code");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_chan.valid)
    else $error("output valid right after reset");
`endif

endmodule
